[rtl/core/alc_pkg.sv]
// Shared types and constants for the audio level log compressor.
package alc_pkg;

    localparam int LOG_IN_W   = 32;
    localparam int LOG_OUT_W  = 22;
    localparam int LOG_FRAC_W = 16;
    localparam int LOG_LAT    = 6;

    localparam logic [15:0] ONE_Q15     = 16'd32768;
    localparam logic [15:0] K_MIN       = 16'd26;
    localparam logic [15:0] ENERGY_KNEE = 16'd26214;

    localparam int DIFF_W  = 13;
    localparam int W_W     = 15;
    localparam int RECIP_W = 27;
    localparam int W_SHIFT = 25;
    // ceil(2^38 / 3277): exact floor of (diff << 13) / 3277 for all diff in range
    localparam logic [RECIP_W-1:0] W_RECIP =
        RECIP_W'(((64'd1 << 38) + 64'd3276) / 64'd3277);

    localparam int DIV_BITS = 20;
    localparam int LA_W     = 20;

    typedef enum logic {
        REG_COMPRESSION_K = 1'b0,
        REG_MAKEUP_GAIN   = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic [15:0]       lin;
        logic              x_le0;
        logic              k_low;
        logic              lb_zero;
        logic              loud;
        logic              trans;
        logic [DIFF_W-1:0] diff;
        logic [W_W-1:0]    w;
    } t_side;

endpackage

[rtl/core/alc_log2.sv]
// Pipelined table-based log2 unit (stages A to F), Q6.16 result.
module alc_log2 #(
    parameter int ENTRIES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [alc_pkg::LOG_IN_W-1:0]  i_v,
    output logic [alc_pkg::LOG_OUT_W-1:0] o_log
);
    import alc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ROM_AW = $clog2(ENTRIES + 1);
    localparam int POS_W = LOG_IN_W + IDX_W;

    function automatic logic [LOG_FRAC_W:0] log_entry(input int unsigned idx);
        logic [63:0]         m;
        logic [LOG_FRAC_W:0] r;
        m = (64'd1 << 30) + ((64'(idx) << 30) / 64'(ENTRIES));
        r = '0;
        if (m >= (64'd2 << 30)) begin
            r = (LOG_FRAC_W + 1)'(1) << LOG_FRAC_W;
        end else begin
            for (int b = LOG_FRAC_W - 1; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30)) begin
                    m = m >> 1;
                    r[b] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    logic [LOG_FRAC_W:0] w_rom [0:ENTRIES];

    for (genvar gi = 0; gi <= ENTRIES; gi++) begin : g_rom
        assign w_rom[gi] = log_entry(gi);
    end

    // stage A: leading one
    logic [LOG_IN_W-1:0] r_a_v;
    logic [4:0]          r_a_e;
    logic [4:0]          n_a_e;

    always_comb begin
        n_a_e = '0;
        for (int i = 0; i < LOG_IN_W; i++) begin
            if (i_v[i]) begin
                n_a_e = 5'(i);
            end
        end
    end

    // stage B: normalize
    logic [LOG_IN_W-1:0] r_b_frac;
    logic [4:0]          r_b_e;
    logic [LOG_IN_W-1:0] w_sh;

    assign w_sh = r_a_v << (~r_a_e);

    // stage C: table position
    logic [POS_W-1:0]    w_pos;
    logic [IDX_W-1:0]    r_c_idx;
    logic [LOG_IN_W-1:0] r_c_rem;
    logic [4:0]          r_c_e;

    assign w_pos = POS_W'(r_b_frac) * POS_W'(ENTRIES);

    // stage D: table read
    logic [LOG_FRAC_W:0]  r_d_e0;
    logic [LOG_FRAC_W:0]  r_d_e1;
    logic [LOG_IN_W-1:0]  r_d_rem;
    logic [4:0]           r_d_e;
    logic [ROM_AW-1:0]    w_ia;
    logic [ROM_AW-1:0]    w_ib;

    assign w_ia = ROM_AW'(r_c_idx);
    assign w_ib = ROM_AW'(r_c_idx) + ROM_AW'(1);

    // stage E: interpolation
    logic [LOG_FRAC_W:0]            w_dlt;
    logic [LOG_IN_W+LOG_FRAC_W:0]   w_prod;
    logic [LOG_FRAC_W:0]            r_e_int;
    logic [LOG_FRAC_W:0]            r_e_e0;
    logic [4:0]                     r_e_e;

    assign w_dlt  = r_d_e1 - r_d_e0;
    assign w_prod = (LOG_IN_W + LOG_FRAC_W + 1)'(w_dlt)
                  * (LOG_IN_W + LOG_FRAC_W + 1)'(r_d_rem);

    // stage F: sum
    logic [LOG_OUT_W-1:0] r_f_log;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_v    <= i_v;
            r_a_e    <= n_a_e;
            r_b_frac <= {w_sh[LOG_IN_W-2:0], 1'b0};
            r_b_e    <= r_a_e;
            r_c_idx  <= w_pos[LOG_IN_W +: IDX_W];
            r_c_rem  <= w_pos[LOG_IN_W-1:0];
            r_c_e    <= r_b_e;
            r_d_e0   <= w_rom[w_ia];
            r_d_e1   <= w_rom[w_ib];
            r_d_rem  <= r_c_rem;
            r_d_e    <= r_c_e;
            r_e_int  <= w_prod[LOG_IN_W +: LOG_FRAC_W + 1];
            r_e_e0   <= r_d_e0;
            r_e_e    <= r_d_e;
            r_f_log  <= LOG_OUT_W'({r_e_e, {LOG_FRAC_W{1'b0}}})
                      + LOG_OUT_W'(r_e_e0) + LOG_OUT_W'(r_e_int);
        end
    end

    assign o_log = r_f_log;

endmodule

[rtl/core/audio_level_log_compressor_unit.sv]
// Top level of the audio level log compressor: APB registers and the main pipeline.
// Pipeline: 1 input stage, 6 log2 stages, 1 subtract stage, 20 restoring divider
//   stages, 4 gain/clamp/blend stages.
// Throughput: one beat per cycle; the whole pipeline holds when the output stalls.
// Reset (synchronous, active low) clears all valid bits and sets compression_k to
//   2560 and makeup_gain to 4096; payload registers are not reset.
module audio_level_log_compressor_unit #(
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic signed [15:0] i_raw_level,
    input  logic [15:0]        i_energy,
    input  logic               i_loud_mode,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_scaled_level,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import alc_pkg::*;

    localparam int S_SUB   = LOG_LAT + 2;
    localparam int S_GAIN  = S_SUB + DIV_BITS + 1;
    localparam int S_CMP   = S_GAIN + 1;
    localparam int S_MUL   = S_CMP + 1;
    localparam int PIPE    = S_MUL + 1;
    localparam int REM_W   = LA_W + DIV_BITS;
    localparam logic [LOG_OUT_W-1:0] LOG_BIAS = LOG_OUT_W'(20) << LOG_FRAC_W;

    // configuration
    logic [15:0] r_k;
    logic [15:0] r_gain;
    t_reg_sel    w_sel;

    assign w_sel  = t_reg_sel'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= 16'd2560;
            r_gain <= 16'd4096;
        end else if (psel && penable && pwrite) begin
            unique case (w_sel)
                REG_COMPRESSION_K: r_k    <= pwdata[15:0];
                REG_MAKEUP_GAIN:   r_gain <= pwdata[15:0];
                default:           r_k    <= r_k;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (w_sel)
                REG_COMPRESSION_K: prdata = {16'h0, r_k};
                REG_MAKEUP_GAIN:   prdata = {16'h0, r_gain};
                default:           prdata = '0;
            endcase
        end
    end

    // pipeline control
    logic            w_en;
    logic [PIPE:1]   r_vld;

    assign w_en       = !r_vld[PIPE] || i_out_ready;
    assign o_in_ready = w_en;
    assign o_out_valid = r_vld[PIPE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE-1:1], i_in_valid};
        end
    end

    // stage 1: input decode
    logic [14:0]         w_xpos;
    logic [15:0]         w_esat;
    t_side               n_side;
    logic [LOG_IN_W-1:0] r_a;
    logic [LOG_IN_W-1:0] r_b;

    always_comb begin
        w_xpos = (!i_raw_level[15] && (i_raw_level != 16'sd0)) ? i_raw_level[14:0] : 15'd0;
        w_esat = (i_energy > ONE_Q15) ? ONE_Q15 : i_energy;
        n_side = '0;
        n_side.x_le0 = (w_xpos == 15'd0);
        if (w_xpos == 15'd0) begin
            n_side.lin = 16'd0;
        end else if (w_xpos >= 15'd4096) begin
            n_side.lin = ONE_Q15;
        end else begin
            n_side.lin = {w_xpos[12:0], 3'b000};
        end
        n_side.k_low = (r_k < K_MIN);
        n_side.loud  = i_loud_mode;
        n_side.trans = i_opcode && (w_esat > ENERGY_KNEE);
        n_side.diff  = n_side.trans ? DIFF_W'(w_esat - ENERGY_KNEE) : '0;
    end

    // energy weight, stage 2
    logic [DIFF_W+RECIP_W-1:0] w_wprod;

    // log outputs
    logic [LOG_OUT_W-1:0] w_log_a;
    logic [LOG_OUT_W-1:0] w_log_b;
    logic [LA_W-1:0]      w_la;
    logic [LA_W-1:0]      w_lb;

    // side data
    t_side r_side [1:S_MUL];
    t_side n_side_w;
    t_side n_side_lb;

    // divider
    logic [REM_W-1:0] r_rem [0:DIV_BITS];
    logic [LA_W-1:0]  r_den [0:DIV_BITS];
    logic [DIV_BITS-1:0] r_q [0:DIV_BITS];

    // tail
    logic [23:0]         r_g;
    logic [15:0]         r_cmp;
    logic [15:0]         r_cmp_d;
    logic [31:0]         r_p_lin;
    logic [31:0]         r_p_cmp;
    logic [15:0]         r_res;
    logic [35:0]         w_gprod;
    logic [15:0]         w_clamp;
    logic [15:0]         n_cmp;
    logic [32:0]         w_sum;
    logic [15:0]         n_res;
    t_side               w_sg;
    t_side               w_sm;
    t_side               w_so;

    assign w_wprod = (DIFF_W + RECIP_W)'(r_side[1].diff) * (DIFF_W + RECIP_W)'(W_RECIP);
    assign w_la    = LA_W'(w_log_a - LOG_BIAS);
    assign w_lb    = LA_W'(w_log_b - LOG_BIAS);

    always_comb begin
        n_side_w          = r_side[1];
        n_side_w.w        = w_wprod[W_SHIFT +: W_W];
        n_side_lb         = r_side[S_SUB-1];
        n_side_lb.lb_zero = (w_lb == '0);
    end

    alc_log2 #(
        .ENTRIES (LOG_TABLE_ENTRIES)
    ) u_log_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r_a),
        .o_log (w_log_a)
    );

    alc_log2 #(
        .ENTRIES (LOG_TABLE_ENTRIES)
    ) u_log_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r_b),
        .o_log (w_log_b)
    );

    assign w_gprod = 36'(r_q[DIV_BITS]) * 36'(r_gain);
    assign w_sg    = r_side[S_GAIN];
    assign w_sm    = r_side[S_CMP];
    assign w_so    = r_side[S_MUL];
    assign w_clamp = (r_g > 24'(ONE_Q15)) ? ONE_Q15 : r_g[15:0];
    assign w_sum   = 33'(r_p_lin) + 33'(r_p_cmp);

    always_comb begin
        if (w_sg.x_le0) begin
            n_cmp = 16'd0;
        end else if (w_sg.k_low || w_sg.lb_zero) begin
            n_cmp = w_sg.lin;
        end else begin
            n_cmp = w_clamp;
        end
    end

    always_comb begin
        priority if (!w_so.loud) begin
            n_res = w_so.lin;
        end else if (!w_so.trans) begin
            n_res = r_cmp_d;
        end else begin
            n_res = w_sum[30:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a       <= 32'h0010_0000 + 32'(r_k * 31'(w_xpos));
            r_b       <= 32'h0010_0000 + 32'({r_k, 12'h000});
            r_side[1] <= n_side;
            r_side[2] <= n_side_w;
            for (int i = 3; i <= S_MUL; i++) begin
                if (i == S_SUB) begin
                    r_side[i] <= n_side_lb;
                end else begin
                    r_side[i] <= r_side[i-1];
                end
            end

            r_rem[0] <= REM_W'(w_la) << 15;
            r_den[0] <= w_lb;
            r_q[0]   <= '0;
            for (int j = 1; j <= DIV_BITS; j++) begin
                r_den[j] <= r_den[j-1];
                if (r_rem[j-1] >= (REM_W'(r_den[j-1]) << (DIV_BITS - j))) begin
                    r_rem[j] <= r_rem[j-1] - (REM_W'(r_den[j-1]) << (DIV_BITS - j));
                    r_q[j]   <= r_q[j-1] | (DIV_BITS'(1) << (DIV_BITS - j));
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_q[j]   <= r_q[j-1];
                end
            end

            r_g     <= w_gprod[35:12];
            r_cmp   <= n_cmp;
            r_p_lin <= 32'(w_sm.lin) * 32'(ONE_Q15 - 16'(w_sm.w));
            r_p_cmp <= 32'(r_cmp) * 32'(w_sm.w);
            r_cmp_d <= r_cmp;
            r_res   <= n_res;
        end
    end

    assign o_scaled_level = r_res;

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_scaled_level <= ONE_Q15))
        else $error("result above full scale");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid result right after reset");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted beat did not enter pipeline");

    a_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[PIPE-1] && !r_side[S_MUL].loud)
        |=> (o_scaled_level == $past(r_side[S_MUL].lin)))
        else $error("normal mode result is not the clamped level");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for audio_level_log_compressor_unit: random traffic and bit-exact prediction.
module tb_top;
    import alc_pkg::*;

    localparam int TABLE_N     = 256;
    localparam int LIMIT       = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam logic [15:0] SPAN_Q15 = 16'd6554;

    typedef struct packed {
        logic               op;
        logic signed [15:0] raw;
        logic [15:0]        energy;
        logic               loud;
    } t_level_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_opcode;
    logic signed [15:0] i_raw_level;
    logic [15:0]        i_energy;
    logic               i_loud_mode;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [15:0]        o_scaled_level;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    audio_level_log_compressor_unit u_top (.*);

    t_level_beat  pending_levels[$];
    logic [15:0]  expected_levels[$];
    logic [31:0]  log_tab[0:TABLE_N];
    logic [15:0]  k_reg;
    logic [15:0]  gain_reg;
    int           errors;
    int           cycles;
    int           send_gap;
    int           recv_stall;
    bit           calm;
    logic         in_fire;
    logic         out_fire;

    function automatic int draw_wait();
        if (calm) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [31:0] table_entry(int i);
        logic [63:0] m;
        logic [31:0] r;
        m = (64'd1 << 30) + ((64'(i) << 30) / TABLE_N);
        r = 0;
        if (m >= (64'd2 << 30)) return 32'd65536;
        for (int b = 15; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] log2_q16(logic [31:0] v);
        int          e;
        logic [63:0] frac;
        logic [63:0] pos;
        logic [63:0] rem;
        logic [31:0] idx;
        logic [31:0] e0;
        logic [31:0] e1;
        if (v == 0) return 0;
        e = 31;
        while (v[e] == 1'b0) e--;
        frac = ({32'd0, v} << (32 - e)) & 64'hFFFF_FFFF;
        pos  = frac * TABLE_N;
        idx  = 32'(pos >> 32);
        rem  = pos & 64'hFFFF_FFFF;
        e0   = log_tab[idx];
        e1   = log_tab[idx + 1];
        return (32'(e) << 16) + e0 + 32'(((64'(e1 - e0)) * rem) >> 32);
    endfunction

    function automatic logic [31:0] linear_level(int x);
        if (x <= 0) return 0;
        if (x >= 4096) return 32'd32768;
        return 32'(x) << 3;
    endfunction

    function automatic logic [31:0] compressed_level(int x);
        logic [31:0] la;
        logic [31:0] lb;
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] c;
        logic [63:0] g;
        if (x <= 0) return 0;
        if (k_reg < K_MIN) return linear_level(x);
        a  = (32'd1 << 20) + 32'(k_reg) * 32'(x);
        b  = (32'd1 << 20) + (32'(k_reg) << 12);
        la = log2_q16(a) - (32'd20 << 16);
        lb = log2_q16(b) - (32'd20 << 16);
        if (lb == 0) return linear_level(x);
        c = (64'(la) << 15) / lb;
        g = (c * gain_reg) >> 12;
        return (g > 64'd32768) ? 32'd32768 : 32'(g);
    endfunction

    function automatic logic [15:0] brightness(t_level_beat it);
        int          x;
        logic [31:0] en;
        logic [31:0] w;
        logic [63:0] lin;
        logic [63:0] cmp;
        x  = int'(it.raw);
        en = (it.energy > ONE_Q15) ? 32'd32768 : 32'(it.energy);
        if (!it.loud) return 16'(linear_level(x));
        if (!it.op || en <= ENERGY_KNEE) return 16'(compressed_level(x));
        w   = ((en - ENERGY_KNEE) << 14) / SPAN_Q15;
        lin = linear_level(x);
        cmp = compressed_level(x);
        return 16'((lin * (64'd32768 - w) + cmp * w) >> 15);
    endfunction

    function automatic t_level_beat random_level();
        t_level_beat it;
        it.op   = 1'($urandom);
        it.loud = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 5))
            0:       it.raw = 16'($urandom);
            1:       it.raw = 16'($urandom_range(4096, 32767));
            default: it.raw = 16'($urandom_range(0, 4200));
        endcase
        case ($urandom_range(0, 3))
            0:       it.energy = 16'($urandom);
            default: it.energy = 16'($urandom_range(24000, 34000));
        endcase
        return it;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (k=%0d gain=%0d)",
                 what, got, want, k_reg, gain_reg);
    endtask

    task automatic reg_write(t_reg_sel sel, logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(sel) << 2;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_COMPRESSION_K) k_reg = value;
        else gain_reg = value;
    endtask

    task automatic drain();
        while (pending_levels.size() != 0 || expected_levels.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        repeat (n) pending_levels.push_back(random_level());
    endtask

    initial begin
        i_clk  = 1'b0;
        cycles = 0;
        forever begin
            #5 i_clk = ~i_clk;
            if (i_clk) begin
                cycles++;
                if (cycles > LIMIT) begin
                    $display("** audio_level_log_compressor_unit: FAILED **");
                    $finish;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        in_fire  <= i_in_valid && o_in_ready;
        out_fire <= o_out_valid && i_out_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_levels.push_back(brightness({i_opcode, i_raw_level, i_energy,
                                                  i_loud_mode}));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_levels.size() == 0) begin
                report("unexpected beat", o_scaled_level, 16'd0);
            end else begin
                logic [15:0] want;
                want = expected_levels.pop_front();
                if (o_scaled_level !== want) report("scaled_level", o_scaled_level, want);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_fire) begin
                if (send_gap != 0) begin
                    i_in_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (pending_levels.size() != 0) begin
                    t_level_beat it;
                    it = pending_levels.pop_front();
                    i_opcode    <= it.op;
                    i_raw_level <= it.raw;
                    i_energy    <= it.energy;
                    i_loud_mode <= it.loud;
                    i_in_valid  <= 1'b1;
                    send_gap    <= draw_wait();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (!i_out_ready || out_fire) begin
                if (recv_stall != 0) begin
                    i_out_ready <= 1'b0;
                    recv_stall  <= recv_stall - 1;
                end else begin
                    i_out_ready <= 1'b1;
                    recv_stall  <= draw_wait();
                end
            end
        end
    end

    initial begin
        t_level_beat d;
        logic signed [15:0] raws[6];
        logic [15:0] ens[5];
        for (int i = 0; i <= TABLE_N; i++) log_tab[i] = table_entry(i);
        errors = 0; calm = 1'b0; send_gap = 0; recv_stall = 0;
        in_fire = 1'b0; out_fire = 1'b0;
        k_reg = 16'd2560; gain_reg = 16'd4096;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0;
        i_opcode = 1'b0; i_raw_level = '0; i_energy = '0; i_loud_mode = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        raws = '{-16'sd32768, 16'sd0, 16'sd1, 16'sd4095, 16'sd4096, 16'sd32767};
        ens  = '{16'd0, 16'd26214, 16'd26215, 16'd32768, 16'd65535};
        foreach (raws[i]) begin
            d = '{1'b0, raws[i], 16'd0, 1'b0}; pending_levels.push_back(d);
            d = '{1'b0, raws[i], 16'd0, 1'b1}; pending_levels.push_back(d);
        end
        foreach (ens[i]) begin
            d = '{1'b1, 16'sd2000, ens[i], 1'b1}; pending_levels.push_back(d);
            d = '{1'b1, 16'sd4096, ens[i], 1'b0}; pending_levels.push_back(d);
        end
        d = '{1'b1, -16'sd1, 16'hFFFF, 1'b1}; pending_levels.push_back(d);
        d = '{1'b0, 16'sh5555, 16'hAAAA, 1'b1}; pending_levels.push_back(d);
        queue_random(30);
        drain();

        calm = 1'b1;
        reg_write(REG_COMPRESSION_K, 16'd0);
        queue_random(50);
        drain();
        calm = 1'b0;
        reg_write(REG_COMPRESSION_K, 16'd25);
        queue_random(50);
        drain();
        reg_write(REG_COMPRESSION_K, 16'd26);
        reg_write(REG_MAKEUP_GAIN, 16'd0);
        queue_random(50);
        drain();
        reg_write(REG_COMPRESSION_K, 16'd65535);
        reg_write(REG_MAKEUP_GAIN, 16'd65535);
        queue_random(60);
        drain();
        reg_write(REG_COMPRESSION_K, 16'd2560);
        reg_write(REG_MAKEUP_GAIN, 16'd4096);
        queue_random(40);
        while (pending_levels.size() != 0 || expected_levels.size() != 0 || i_in_valid)
            @(posedge i_clk);
        queue_random(40);
        drain();
        for (int p = 0; p < 5; p++) begin
            calm = (p == 2);
            reg_write(REG_COMPRESSION_K, 16'($urandom));
            reg_write(REG_MAKEUP_GAIN, 16'($urandom_range(0, 12000)));
            queue_random(50);
            drain();
        end

        if (errors == 0) begin
            $display("** audio_level_log_compressor_unit: PASSED **");
        end else begin
            $display("** audio_level_log_compressor_unit: FAILED **");
        end
        $finish;
    end

endmodule
